// ===== src/sts_pkg.sv =====
// Package for the sorted table search block: payload structs, register
// indexes, state encoding and sizing constants. No dependencies.
`timescale 1ns / 1ps
package sts_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CountW = IdxW + 1;
  localparam int unsigned DataW = 32;
  // Quotient bits: the probe offset is at most the span, which is below the depth.
  localparam int unsigned QuoW = IdxW;
  // Dividend is span (IdxW bits) times a 33-bit difference.
  localparam int unsigned DivW = IdxW + DataW + 1;

  localparam logic [0:0] RegEntryCount = 1'd0;
  localparam logic [0:0] RegSearchMode = 1'd1;

  localparam logic KindWrite = 1'b0;
  localparam logic KindSearch = 1'b1;

  typedef struct packed {
    logic kind;
    logic [9:0] entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] search_key;
  } in_word_t;

  typedef struct packed {
    logic found;
    logic [9:0] match_index;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_RD_POS,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

// ===== src/sorted_table_search_top.sv =====
// Sorted table search top level: one 1024x32 table memory and a search
// sequencer with a restoring divider. Depends on sts_pkg.
`timescale 1ns / 1ps
// A write word is stored at its accepting edge. A binary search probe reads
// the midpoint, then compares. An interpolation probe reads both ends,
// multiplies, runs 43 divider steps, reads the probe and compares; with equal
// ends it reads the low end and compares. The probe count depends on the data.
// One word is in work at a time; the next waits until the result word is taken.
// Reset clears config, state and result flag; entries are undefined until written.
module sorted_table_search_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output sts_pkg::out_word_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IdxW = sts_pkg::IdxW;
  localparam int unsigned CountW = sts_pkg::CountW;
  localparam int unsigned DivW = sts_pkg::DivW;
  localparam logic signed [CountW:0] StepOne = (CountW + 1)'(1);

  // Configuration registers. The user writes only while the block is idle; unenforced.
  logic [CountW-1:0] entry_count;
  logic search_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      search_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sts_pkg::RegEntryCount: entry_count <= cfg_data[CountW-1:0];
        sts_pkg::RegSearchMode: search_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Entry count saturated to the table depth.
  logic [CountW-1:0] count_sat;
  assign count_sat = (entry_count > CountW'(sts_pkg::TableDepth)) ?
                     CountW'(sts_pkg::TableDepth) : entry_count;

  // Table memory: one write or one read port use per cycle, registered read.
  logic signed [31:0] table_mem [sts_pkg::TableDepth];
  logic mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic signed [31:0] mem_wdata;
  logic mem_re;
  logic [IdxW-1:0] mem_raddr;
  logic signed [31:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= table_mem[mem_raddr];
    end
  end

  // Sequencer state. lo and hi carry one extra bit so that hi may be -1
  // and lo may step past the top; signed compare handles the empty range.
  sts_pkg::state_t state, state_next;
  logic signed [CountW:0] lo, lo_next, hi, hi_next, pos, pos_next;
  logic signed [31:0] key, key_next;
  logic signed [31:0] alo, alo_next;
  logic [DivW-1:0] rem, rem_next;
  logic [DivW-1:0] quo, quo_next;
  logic [32:0] den, den_next;
  logic [5:0] step, step_next;
  logic mode, mode_next;
  sts_pkg::out_word_t res, res_next;
  logic res_valid, res_valid_next;

  logic in_fire;
  assign in_fire = in_valid && !in_stall;
  assign in_stall = (state != sts_pkg::ST_IDLE) || res_valid;
  assign out_valid = res_valid;
  assign out_data = res;

  // Restoring divider step: shift in the next dividend bit from quo.
  logic [DivW:0] trial;
  logic [DivW-1:0] rem_sh;
  assign rem_sh = {rem[DivW-2:0], quo[DivW-1]};
  assign trial = {1'b0, rem_sh} - {{(DivW - 33){1'b0}}, 1'b0, den};

  logic signed [CountW:0] span;
  logic [32:0] num33;
  assign span = hi - lo;
  assign num33 = 33'(signed'({key[31], key}) - signed'({alo[31], alo}));

  logic signed [CountW:0] probe;
  always_comb begin
    probe = lo + (CountW + 1)'(signed'({1'b0, quo[IdxW:0]}));
    if (probe > hi) begin
      probe = hi;
    end
  end

  always_comb begin
    state_next = state;
    lo_next = lo;
    hi_next = hi;
    pos_next = pos;
    key_next = key;
    alo_next = alo;
    rem_next = rem;
    quo_next = quo;
    den_next = den;
    step_next = step;
    mode_next = mode;
    res_next = res;
    res_valid_next = res_valid;
    mem_we = 1'b0;
    mem_waddr = in_data.entry_index;
    mem_wdata = in_data.entry_value;
    mem_re = 1'b0;
    mem_raddr = pos[IdxW-1:0];

    if (res_valid && !out_stall) begin
      res_valid_next = 1'b0;
    end

    unique case (state)
      sts_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == sts_pkg::KindWrite) begin
            mem_we = 1'b1;
          end else begin
            key_next = in_data.search_key;
            mode_next = search_mode;
            lo_next = '0;
            hi_next = (CountW + 1)'(signed'({1'b0, count_sat})) - StepOne;
            state_next = sts_pkg::ST_CHECK;
          end
        end
      end
      sts_pkg::ST_CHECK: begin
        // Range test, then the first read of this probe.
        if (lo > hi) begin
          res_next = '0;
          res_valid_next = 1'b1;
          state_next = sts_pkg::ST_IDLE;
        end else if (!mode) begin
          pos_next = lo + ((hi - lo) >>> 1);
          mem_re = 1'b1;
          mem_raddr = pos_next[IdxW-1:0];
          state_next = sts_pkg::ST_CMP;
        end else begin
          mem_re = 1'b1;
          mem_raddr = lo[IdxW-1:0];
          state_next = sts_pkg::ST_RD_LO;
        end
      end
      sts_pkg::ST_RD_LO: begin
        alo_next = mem_rdata;
        mem_re = 1'b1;
        mem_raddr = hi[IdxW-1:0];
        state_next = sts_pkg::ST_RD_HI;
      end
      sts_pkg::ST_RD_HI: begin
        if (key < alo || key > mem_rdata) begin
          res_next = '0;
          res_valid_next = 1'b1;
          state_next = sts_pkg::ST_IDLE;
        end else if (lo == hi) begin
          res_next.found = (alo == key);
          res_next.match_index = (alo == key) ? lo[IdxW-1:0] : '0;
          res_valid_next = 1'b1;
          state_next = sts_pkg::ST_IDLE;
        end else if (mem_rdata == alo) begin
          pos_next = lo;
          mem_re = 1'b1;
          mem_raddr = lo[IdxW-1:0];
          state_next = sts_pkg::ST_CMP;
        end else begin
          den_next = 33'(signed'({mem_rdata[31], mem_rdata}) - signed'({alo[31], alo}));
          state_next = sts_pkg::ST_MUL;
        end
      end
      sts_pkg::ST_MUL: begin
        // 10 x 33 product, registered before the divider runs.
        quo_next = DivW'(span[IdxW-1:0]) * DivW'(num33);
        rem_next = '0;
        step_next = 6'(DivW);
        state_next = sts_pkg::ST_DIV;
      end
      sts_pkg::ST_DIV: begin
        if (step == '0) begin
          pos_next = probe;
          mem_re = 1'b1;
          mem_raddr = probe[IdxW-1:0];
          state_next = sts_pkg::ST_CMP;
        end else begin
          if (!trial[DivW]) begin
            rem_next = trial[DivW-1:0];
            quo_next = {quo[DivW-2:0], 1'b1};
          end else begin
            rem_next = rem_sh;
            quo_next = {quo[DivW-2:0], 1'b0};
          end
          step_next = step - 6'd1;
        end
      end
      sts_pkg::ST_RD_POS: begin
        state_next = sts_pkg::ST_CMP;
      end
      sts_pkg::ST_CMP: begin
        if (mem_rdata == key) begin
          res_next.found = 1'b1;
          res_next.match_index = pos[IdxW-1:0];
          res_valid_next = 1'b1;
          state_next = sts_pkg::ST_IDLE;
        end else begin
          if (mem_rdata < key) begin
            lo_next = pos + StepOne;
          end else begin
            hi_next = pos - StepOne;
          end
          state_next = sts_pkg::ST_CHECK;
        end
      end
      sts_pkg::ST_DONE: begin
        state_next = sts_pkg::ST_IDLE;
      end
      default: state_next = sts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sts_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
    pos <= pos_next;
    key <= key_next;
    alo <= alo_next;
    rem <= rem_next;
    quo <= quo_next;
    den <= den_next;
    step <= step_next;
    mode <= mode_next;
    res <= res_next;
  end

`ifndef SYNTHESIS
  // A result never appears while the sequencer is mid-search.
  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> state == sts_pkg::ST_IDLE)
    else $error("result raised outside idle");

  // A held result does not change while stalled.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_stall |=> res_valid && $stable(res))
    else $error("result changed under stall");

  // A not-found result carries index zero.
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.found |-> res.match_index == '0)
    else $error("nonzero index on miss");

  // The divider only runs against a nonzero divisor.
  a_den_nz: assert property (@(posedge clk) disable iff (rst)
    state == sts_pkg::ST_DIV |-> den != '0)
    else $error("zero divisor in divider");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for sorted_table_search_top: loads the table, searches it
// in both modes and checks every result word against an in-bench predictor.
// Depends on sts_pkg and sorted_table_search_top.
`timescale 1ns / 1ps
module tb_top;

  localparam int WatchdogLimit = 400000;
  localparam int DrainCycles = 64;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  sts_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  sts_pkg::out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  sorted_table_search_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the block's table and registers. The table is loaded in
  // full before the first search, so no search ever reads an unwritten entry.
  logic signed [31:0] shadow_table [sts_pkg::TableDepth];
  int unsigned shadow_count;
  logic shadow_mode;

  // Search answers waiting for their result word, oldest first.
  sts_pkg::out_word_t pending_answers[$];

  int idle_pct;
  int stall_pct;
  int mismatches = 0;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predicts the answer of one search from the shadow state. The
  // interpolation probe uses exact integer floor division; a range whose
  // ends hold the same value probes its low end.
  function automatic sts_pkg::out_word_t predict_search(logic signed [31:0] key);
    longint n;
    longint lo;
    longint hi;
    longint pos;
    longint hit;
    longint alo;
    longint ahi;
    longint unsigned span;
    longint unsigned num;
    longint unsigned den;
    sts_pkg::out_word_t r;
    n = (shadow_count > sts_pkg::TableDepth) ? sts_pkg::TableDepth : shadow_count;
    lo = 0;
    hi = n - 1;
    hit = -1;
    if (!shadow_mode) begin
      while (lo <= hi && hit < 0) begin
        pos = lo + (hi - lo) / 2;
        if (shadow_table[pos] == key) hit = pos;
        else if (shadow_table[pos] < key) lo = pos + 1;
        else hi = pos - 1;
      end
    end else begin
      while (hit < 0 && lo <= hi && key >= shadow_table[lo] && key <= shadow_table[hi]) begin
        if (lo == hi) begin
          if (shadow_table[lo] == key) hit = lo;
          break;
        end
        alo = shadow_table[lo];
        ahi = shadow_table[hi];
        if (alo == ahi) begin
          pos = lo;
        end else begin
          span = hi - lo;
          num = longint'(key) - alo;
          den = ahi - alo;
          pos = lo + longint'((span * num) / den);
        end
        if (pos < lo) pos = lo;
        if (pos > hi) pos = hi;
        if (shadow_table[pos] == key) hit = pos;
        else if (shadow_table[pos] < key) lo = pos + 1;
        else hi = pos - 1;
      end
    end
    r.found = (hit >= 0);
    r.match_index = (hit >= 0) ? hit[9:0] : '0;
    return r;
  endfunction

  // Sends one word, with a random gap first when the sender is idling.
  // Valid stays high afterwards so back-to-back words never drop it.
  task automatic send_word(sts_pkg::in_word_t w);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (w.kind == sts_pkg::KindSearch)
      pending_answers.push_back(predict_search(w.search_key));
    else shadow_table[w.entry_index] = w.entry_value;
  endtask

  task automatic write_entry(int idx, logic signed [31:0] value);
    sts_pkg::in_word_t w;
    w.kind = sts_pkg::KindWrite;
    w.entry_index = idx[9:0];
    w.entry_value = value;
    w.search_key = $urandom;
    send_word(w);
  endtask

  task automatic search_key(logic signed [31:0] key);
    sts_pkg::in_word_t w;
    w.kind = sts_pkg::KindSearch;
    w.entry_index = $urandom;
    w.entry_value = $urandom;
    w.search_key = key;
    send_word(w);
  endtask

  // Register writes happen only with the block idle: every answer back and
  // enough cycles for a trailing table write to retire.
  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sts_pkg::RegEntryCount) shadow_count = value[10:0];
    else shadow_mode = value[0];
  endtask

  // Writes entries 0..n-1 in nondecreasing order; the step size is drawn
  // per call so that both dense runs with duplicates and sparse tables occur.
  task automatic fill_sorted(int n);
    longint v;
    longint step_max;
    int sel;
    sel = $urandom_range(3);
    step_max = (sel == 0) ? 1 : (sel == 1) ? 100 : (sel == 2) ? 65536 : 1 << 24;
    v = longint'($signed($urandom)) / ((sel == 3) ? 1 : 4);
    for (int i = 0; i < n; i++) begin
      if (v > 2147483647) v = 2147483647;
      write_entry(i, v[31:0]);
      v = v + $urandom_range(0, step_max);
    end
  endtask

  // Picks a key: mostly a value in the active range, else a neighbor or noise.
  function automatic logic signed [31:0] pick_key(int n);
    int sel;
    logic signed [31:0] k;
    sel = $urandom_range(3);
    k = shadow_table[(n > 0) ? $urandom_range(n - 1) : 0];
    if (sel == 2) k = k + ($urandom_range(1) ? 1 : -1);
    else if (sel == 3) k = $urandom;
    return k;
  endfunction

  task automatic test_table_load();
    write_reg(sts_pkg::RegEntryCount, 32'd0);
    write_reg(sts_pkg::RegSearchMode, 32'd0);
    fill_sorted(sts_pkg::TableDepth);
    write_entry(0, 32'sh8000_0000);
    write_entry(sts_pkg::TableDepth - 1, 32'sh7fff_ffff);
  endtask

  // Directed corners: empty table, extremes of the key, saturated count,
  // and an interpolation range whose ends are equal.
  task automatic test_directed();
    search_key(32'sd0);
    write_reg(sts_pkg::RegEntryCount, 32'd1024);
    search_key(32'sh8000_0000);
    search_key(32'sh7fff_ffff);
    search_key(shadow_table[517]);
    write_reg(sts_pkg::RegSearchMode, 32'd1);
    search_key(32'sh8000_0000);
    search_key(32'sh7fff_ffff);
    search_key(shadow_table[300]);
    search_key(shadow_table[300] + 1);
    write_reg(sts_pkg::RegEntryCount, 32'h7ff);
    search_key(shadow_table[900]);
    for (int i = 0; i < 8; i++) write_entry(i, 32'sd5);
    write_reg(sts_pkg::RegEntryCount, 32'd8);
    search_key(32'sd5);
    search_key(32'sd6);
    search_key(32'sd4);
    write_reg(sts_pkg::RegEntryCount, 32'd1);
    search_key(32'sd5);
    search_key(32'sd7);
  endtask

  // One random phase: blocks of a fresh setting, for most blocks a table refill,
  // and a burst of searches, with an occasional out-of-order write as noise.
  task automatic test_random_phase(int idle, int stall, int items);
    int done;
    int n;
    int sel;
    idle_pct = idle;
    stall_pct = stall;
    done = 0;
    while (done < items) begin
      sel = $urandom_range(7);
      n = (sel == 0) ? ((shadow_mode) ? 64 : 1024) : (sel == 1) ? 1 : $urandom_range(2, 40);
      write_reg(sts_pkg::RegSearchMode, {31'd0, 1'($urandom_range(1))});
      if (sel == 0 && !shadow_mode)
        write_reg(sts_pkg::RegEntryCount, 32'h400 | $urandom_range(0, 1) << 10);
      else write_reg(sts_pkg::RegEntryCount, n);
      if (sel != 0) begin
        fill_sorted(n);
        done += n;
      end
      if ($urandom_range(4) == 0) begin
        write_entry($urandom_range(n - 1), $urandom);
        done++;
      end
      repeat ($urandom_range(8, 20)) begin
        search_key(pick_key(n));
        done++;
      end
    end
  endtask

  // Result checking, receiver stalls and the watchdog.
  always @(posedge clk) begin
    sts_pkg::out_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_top: errors");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", out_data);
        end else begin
          want = pending_answers.pop_front();
          if (out_data.found !== want.found || out_data.match_index !== want.match_index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                       want.found, want.match_index, out_data.found, out_data.match_index);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    shadow_count = 0;
    shadow_mode = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_random_phase(0, 0, 60);
    test_random_phase(54, 0, 60);
    test_random_phase(0, 54, 60);
    test_random_phase(12, 12, 60);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
